[src/pressure_average_flow_calc_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pressure average flow block
// Each macro yields one labeled concurrent assertion, or nothing at all when
// NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_AVERAGE_FLOW_CALC_MACROS_SVH
`define PRESSURE_AVERAGE_FLOW_CALC_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PAFC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define PAFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PAFC_ASSERT_IMP(label, clk, rst, ante, cons, msg)

`define PAFC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[src/pafc_pkg.sv]
// ----------------------------------------------------------------------------
// pafc_pkg
// Shared widths, constants, register indexes and ring command type.
// ----------------------------------------------------------------------------
package pafc_pkg;

  localparam int P_W     = 24;  // pressure and flow width
  localparam int S_W     = 16;  // converter sample width
  localparam int GAIN_W  = 24;
  localparam int COEFF_W = 16;
  localparam int KPA_W   = 13;
  localparam int RAD_W   = 38;  // (|p| * kPa factor) << 2 fits here
  localparam int ROOT_W  = RAD_W / 2;
  localparam int Q_W     = 21;  // (root * coeff) >> 14 never exceeds this

  // cmH2O to kPa, Q16
  localparam logic [KPA_W-1:0] KPA_Q16 = 13'd6427;

  localparam logic signed [P_W-1:0] P_MAX = 24'sh7FFFFF;
  localparam logic signed [P_W-1:0] P_MIN = -24'sh800000;

  localparam logic [GAIN_W-1:0]  GAIN_RESET  = 24'd65536;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd60;

  typedef enum logic [1:0] {
    REG_CHANNEL_SELECT = 2'd0,
    REG_PRESSURE_GAIN  = 2'd1,
    REG_PRESSURE_BIAS  = 2'd2,
    REG_FLOW_COEFF     = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ring_cmd_t;

endpackage

[src/pafc_ring.sv]
// ----------------------------------------------------------------------------
// pafc_ring
// Pressure ring memory with running window sum, write slot and wrap flag.
// ----------------------------------------------------------------------------
module pafc_ring #(
  parameter int WINDOW = 16,
  parameter int SUM_W  = 28
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pafc_pkg::ring_cmd_t           cmd,
  input  logic signed [pafc_pkg::P_W-1:0] raw,
  output logic signed [SUM_W-1:0]       window_sum,
  output logic                          ring_wrapped
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);

  logic signed [pafc_pkg::P_W-1:0] mem [WINDOW];
  logic signed [pafc_pkg::P_W-1:0] rd_data;
  logic [SLOT_W-1:0]               write_slot;
  logic signed [SUM_W-1:0]         old_val;

  // Slots are filled in order, so before the first wrap the slot read was
  // never written and counts as zero.
  assign old_val = ring_wrapped ? SUM_W'(rd_data) : '0;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data <= mem[write_slot];
    end
    if (cmd.wr_en) begin
      mem[write_slot] <= raw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum   <= '0;
      write_slot   <= '0;
      ring_wrapped <= 1'b0;
    end else if (cmd.wr_en) begin
      window_sum <= window_sum - old_val + SUM_W'(raw);
      if (write_slot == LAST_SLOT) begin
        write_slot   <= '0;
        ring_wrapped <= 1'b1;
      end else begin
        write_slot <= write_slot + 1'b1;
      end
    end
  end

endmodule

[src/pafc_isqrt.sv]
// ----------------------------------------------------------------------------
// pafc_isqrt
// Bit-serial floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module pafc_isqrt (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [pafc_pkg::RAD_W-1:0]      radicand,
  output logic                            done,
  output logic [pafc_pkg::ROOT_W-1:0]     root
);

  localparam int RW    = pafc_pkg::ROOT_W;
  localparam int CNT_W = $clog2(RW);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(RW - 1);

  logic [pafc_pkg::RAD_W-1:0] rad_sh;
  logic [RW:0]                rem;
  logic [CNT_W-1:0]           cnt;
  logic                       busy;
  logic [RW+2:0]              rem_sh;
  logic [RW+2:0]              trial;
  logic                       fits;

  assign rem_sh = {rem, rad_sh[pafc_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[pafc_pkg::RAD_W-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_sh[RW:0] - trial[RW:0];
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh[RW:0];
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= busy && (cnt == LAST);
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == LAST) begin
          busy <= 1'b0;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

[src/pressure_average_flow_calc.sv]
// ----------------------------------------------------------------------------
// pressure_average_flow_calc
// Differential pressure to flow: channel pick, linear scale, moving average
// over a ring memory and a square-root flow law.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry both converter samples (sample_ch0, sample_ch1) on a
//   valid/ready channel; each beat yields one output beat with raw_pressure,
//   filtered_pressure, window_full and flow on a second valid/ready channel.
//   Registers are written through cfg_write/cfg_index/cfg_data; the user must
//   write them only while idle, and the block itself has no check for this.
//   out_valid rises once the beat has passed the scale, ring read, ring update,
//   filter, kPa, 19-step bit-serial square root and multiply steps.
//   Items are processed one at a time: in_ready is high only when the
//   sequencer is idle and reset is low. A finished result sits in the output
//   register, so the next beat is taken and worked on while the receiver
//   stalls; that beat waits at its last step until the output register is free.
//   Reset clears the registers to their defaults, the window sum, write slot
//   and wrap flag. The ring memory itself is not cleared: slots not yet
//   written since reset read as zero because the ring fills in order.
//   Before the first wrap filtered_pressure repeats raw_pressure.
// ----------------------------------------------------------------------------
module pressure_average_flow_calc #(
  parameter int WINDOW = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   cfg_write,
  input  logic [1:0]                             cfg_index,
  input  logic [pafc_pkg::P_W-1:0]               cfg_data,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [pafc_pkg::S_W-1:0]        sample_ch0,
  input  logic signed [pafc_pkg::S_W-1:0]        sample_ch1,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [pafc_pkg::P_W-1:0]        raw_pressure,
  output logic signed [pafc_pkg::P_W-1:0]        filtered_pressure,
  output logic                                   window_full,
  output logic signed [pafc_pkg::P_W-1:0]        flow
);

`include "pressure_average_flow_calc_macros.svh"

  localparam int P_W   = pafc_pkg::P_W;
  localparam int SUM_W = P_W + $clog2(WINDOW);
  localparam int SHIFT = $clog2(WINDOW + 1) - 1;
  localparam int PROD_W = pafc_pkg::S_W + pafc_pkg::GAIN_W;
  localparam int KP_W   = P_W + pafc_pkg::KPA_W;
  localparam int QP_W   = pafc_pkg::ROOT_W + pafc_pkg::COEFF_W;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_SCALE = 9'b000000010,
    ST_READ  = 9'b000000100,
    ST_UPD   = 9'b000001000,
    ST_FILT  = 9'b000010000,
    ST_KPA   = 9'b000100000,
    ST_SQRT  = 9'b001000000,
    ST_MUL   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_t;

  state_t state, state_next;

  // configuration
  logic                            channel_select;
  logic [pafc_pkg::GAIN_W-1:0]     pressure_gain;
  logic signed [P_W-1:0]           pressure_bias;
  logic [pafc_pkg::COEFF_W-1:0]    flow_coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_select <= 1'b0;
      pressure_gain  <= pafc_pkg::GAIN_RESET;
      pressure_bias  <= '0;
      flow_coeff     <= pafc_pkg::COEFF_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        pafc_pkg::REG_CHANNEL_SELECT: channel_select <= cfg_data[0];
        pafc_pkg::REG_PRESSURE_GAIN:  pressure_gain  <= cfg_data;
        pafc_pkg::REG_PRESSURE_BIAS:  pressure_bias  <= $signed(cfg_data);
        pafc_pkg::REG_FLOW_COEFF:     flow_coeff     <= cfg_data[pafc_pkg::COEFF_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath
  logic                             in_beat;
  logic signed [pafc_pkg::S_W-1:0]  sample_sel;
  logic signed [PROD_W:0]           prod_full;
  logic signed [PROD_W-1:0]         prod;
  logic signed [P_W:0]              biased;
  logic signed [P_W-1:0]            raw_sat;
  logic signed [P_W-1:0]            raw_reg;
  logic signed [SUM_W-1:0]          window_sum;
  logic                             ring_wrapped;
  logic signed [SUM_W-1:0]          avg;
  logic signed [P_W-1:0]            avg_sat;
  logic signed [P_W-1:0]            filt_reg;
  logic [P_W-1:0]                   mag;
  logic [KP_W-1:0]                  kprod;
  logic [pafc_pkg::RAD_W-1:0]       radicand;
  logic                             sq_start;
  logic                             sq_done;
  logic [pafc_pkg::ROOT_W-1:0]      root;
  logic [QP_W-1:0]                  qprod;
  logic [P_W-1:0]                   q_ext;
  logic                             filt_pos;
  logic                             out_load;
  pafc_pkg::ring_cmd_t              ring_cmd;

  assign in_ready   = (state == ST_IDLE) && !rst;
  assign in_beat    = in_valid && in_ready;
  assign sample_sel = channel_select ? sample_ch1 : sample_ch0;
  assign prod_full  = sample_sel * $signed({1'b0, pressure_gain});

  // floor shift by 16 is the upper slice; add bias, then clamp to 24 bits
  assign biased  = {prod[PROD_W-1], prod[PROD_W-1 -: P_W]} +
                   {pressure_bias[P_W-1], pressure_bias};
  assign raw_sat = (biased[P_W] != biased[P_W-1]) ?
                   (biased[P_W] ? pafc_pkg::P_MIN : pafc_pkg::P_MAX) :
                   biased[P_W-1:0];

  assign avg     = window_sum >>> SHIFT;
  assign avg_sat = (avg > SUM_W'(pafc_pkg::P_MAX)) ? pafc_pkg::P_MAX :
                   (avg < SUM_W'(pafc_pkg::P_MIN)) ? pafc_pkg::P_MIN :
                   avg[P_W-1:0];

  assign mag      = filt_reg[P_W-1] ? (~filt_reg + 1'b1) : filt_reg;
  assign kprod    = mag * pafc_pkg::KPA_Q16;
  assign radicand = {kprod[pafc_pkg::RAD_W-3:0], 2'b00};
  assign sq_start = (state == ST_KPA);

  assign ring_cmd.rd_en = (state == ST_READ);
  assign ring_cmd.wr_en = (state == ST_UPD);

  // q stays below 2^21, so no clamp is needed before the sign
  assign q_ext    = P_W'(qprod[14 +: pafc_pkg::Q_W]);
  assign filt_pos = !filt_reg[P_W-1] && (filt_reg != '0);
  assign out_load = (state == ST_DONE) && (!out_valid || out_ready);

  pafc_ring #(
    .WINDOW (WINDOW),
    .SUM_W  (SUM_W)
  ) u_ring (
    .clk          (clk),
    .rst          (rst),
    .cmd          (ring_cmd),
    .raw          (raw_reg),
    .window_sum   (window_sum),
    .ring_wrapped (ring_wrapped)
  );

  pafc_isqrt u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (radicand),
    .done     (sq_done),
    .root     (root)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_beat) state_next = ST_SCALE;
      ST_SCALE: state_next = ST_READ;
      ST_READ:  state_next = ST_UPD;
      ST_UPD:   state_next = ST_FILT;
      ST_FILT:  state_next = ST_KPA;
      ST_KPA:   state_next = ST_SQRT;
      ST_SQRT:  if (sq_done) state_next = ST_MUL;
      ST_MUL:   state_next = ST_DONE;
      ST_DONE:  if (out_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      prod <= prod_full[PROD_W-1:0];
    end
    if (state == ST_SCALE) begin
      raw_reg <= raw_sat;
    end
    // wrap flag and sum already include this beat here
    if (state == ST_FILT) begin
      filt_reg <= ring_wrapped ? avg_sat : raw_reg;
    end
    if (state == ST_MUL) begin
      qprod <= root * flow_coeff;
    end
    if (out_load) begin
      raw_pressure      <= raw_reg;
      filtered_pressure <= filt_reg;
      window_full       <= ring_wrapped;
      flow              <= filt_pos ? $signed(q_ext) : -$signed(q_ext);
    end
  end

  `PAFC_ASSERT_NEXT(a_ring_rd_then_wr, clk, rst, ring_cmd.rd_en, ring_cmd.wr_en, "ring write did not follow read")

  `PAFC_ASSERT_IMP(a_sqrt_done_in_sqrt, clk, rst, sq_done, state == ST_SQRT, "square root finished outside its step")

  `PAFC_ASSERT_IMP(a_passthrough, clk, rst, out_valid && !window_full, filtered_pressure == raw_pressure, "filtered differs from raw before wrap")

  `PAFC_ASSERT_IMP(a_flow_sign, clk, rst, out_valid && (filtered_pressure[P_W-1] || filtered_pressure == '0), flow[P_W-1] || flow == '0, "positive flow from non-positive pressure")

endmodule
